FILE: hw/rtl/hpbf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the high-pass box filter.
// No dependencies.
package hpbf_pkg;

   localparam int PIX_W     = 8;   // pixel width
   localparam int POS_W     = 11;  // row/column tag width on the result word
   localparam int KSZ_W     = 4;   // kernel_size register width
   localparam int DIM_W     = 12;  // image_width / image_height register width
   localparam int KN_W      = 5;   // effective kernel edge (at most 15), field holds up to 31
   localparam int CSR_IDX_W = 2;
   localparam int GRP       = 4;   // adder group size in the sum trees

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL_SIZE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_idx_type;

   // Per-word control that travels down the pipeline
   typedef struct packed {
      logic             valid;
      logic             emit;
      logic             last;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } tag_type;

endpackage

FILE: hw/rtl/high_pass_box_filter.sv
`timescale 1ns / 1ps
// High-pass N x N box filter, one pixel word per clock when rsp_tready is high.
// Stages from req word accepted to rsp_tvalid: position and line memory read,
// column sum, window sum, clamp. Throughput: 1 word per cycle unless the output
// stalls, set by the single read-modify-write of the line memory per column.
// Reset: synchronous, clears positions, window registers and pipeline valids;
// registers return to N=3, 512 x 512. The line memory is not cleared.
module high_pass_box_filter
   import hpbf_pkg::*;
#(
   parameter int MAX_KERNEL = 15,
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] pixel
   input  logic                 req_tuser,   // [0] start_of_frame
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [7:0] filtered_value, [18:8] out_row,
                                             // [29:19] out_col, rest zero
   output logic                 rsp_tlast,   // last_of_frame
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int NG = (MAX_KERNEL - 1 + GRP - 1) / GRP;
   localparam int GW = PIX_W + 2;

   logic [KSZ_W-1:0] kernel_size_ff;
   logic [DIM_W-1:0] image_width_ff, image_height_ff;
   logic [KN_W-1:0]  kern_n, kclip;
   logic [WW-1:0]    img_w;
   logic [HW-1:0]    img_h;
   logic             en;
   logic [CW-1:0]    rd_col, s1_col;
   tag_type          s1_tag, s2_tag, out_tag;
   logic [PIX_W-1:0] s1_pix, s2_pix, s2_center, out_value;
   logic [GW-1:0]    s2_grp [NG];

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_size_ff  <= KSZ_W'(3);
         image_width_ff  <= DIM_W'(512);
         image_height_ff <= DIM_W'(512);
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_KERNEL_SIZE:  kernel_size_ff  <= csr_data[KSZ_W-1:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective kernel edge and frame size
   always_comb begin
      kclip = (32'(kernel_size_ff) > 32'(MAX_KERNEL)) ? KN_W'(MAX_KERNEL)
                                                      : KN_W'(kernel_size_ff);
      if (!kclip[0] && (kclip != '0)) begin
         kclip = kclip - KN_W'(1);
      end
      kern_n = (kclip < KN_W'(3)) ? KN_W'(3) : kclip;
      if (image_width_ff == '0) begin
         img_w = WW'(1);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         img_w = WW'(MAX_WIDTH);
      end else begin
         img_w = WW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         img_h = HW'(1);
      end else if (32'(image_height_ff) > 32'(MAX_HEIGHT)) begin
         img_h = HW'(MAX_HEIGHT);
      end else begin
         img_h = HW'(image_height_ff);
      end
   end

   // whole pipeline advances whenever the output word can move
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   hpbf_pos #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pos (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_pix   (req_tdata),
      .in_sof   (req_tuser),
      .kern_n   (kern_n),
      .img_w    (img_w),
      .img_h    (img_h),
      .rd_col   (rd_col),
      .s1_tag   (s1_tag),
      .s1_pix   (s1_pix),
      .s1_col   (s1_col)
   );

   hpbf_line #(
      .MAX_KERNEL (MAX_KERNEL),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_line (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .rd_col    (rd_col),
      .s1_tag    (s1_tag),
      .s1_pix    (s1_pix),
      .s1_col    (s1_col),
      .kern_n    (kern_n),
      .s2_tag    (s2_tag),
      .s2_pix    (s2_pix),
      .s2_center (s2_center),
      .s2_grp    (s2_grp)
   );

   hpbf_win #(
      .MAX_KERNEL (MAX_KERNEL)
   ) u_win (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .kern_n    (kern_n),
      .s2_tag    (s2_tag),
      .s2_pix    (s2_pix),
      .s2_center (s2_center),
      .s2_grp    (s2_grp),
      .rsp_valid (rsp_tvalid),
      .rsp_value (out_value),
      .rsp_tag   (out_tag)
   );

   // result word
   assign rsp_tdata = {2'b00, out_tag.col, out_tag.row, out_value};
   assign rsp_tlast = out_tag.last;

endmodule

FILE: hw/rtl/hpbf_pos.sv
`timescale 1ns / 1ps
// Raster position tracking and window-complete decision (stage 0 -> 1).
// Depends on hpbf_pkg.
module hpbf_pos
   import hpbf_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int RW = $clog2(MAX_HEIGHT),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [PIX_W-1:0] in_pix,
   input  logic             in_sof,
   input  logic [KN_W-1:0]  kern_n,
   input  logic [WW-1:0]    img_w,
   input  logic [HW-1:0]    img_h,
   output logic [CW-1:0]    rd_col,
   output tag_type          s1_tag,
   output logic [PIX_W-1:0] s1_pix,
   output logic [CW-1:0]    s1_col
);

   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   r0, r2;
   logic [CW-1:0]   c0, c1;
   logic [HW-1:0]   r1, row_nx;
   logic [WW-1:0]   col_nx;
   logic [KN_W-1:0] half;
   logic            emit, last;

   // position of this word, with frame start and wrap applied first
   always_comb begin
      r0   = in_sof ? '0 : row_ff;
      c0   = in_sof ? '0 : col_ff;
      half = kern_n >> 1;
      if (WW'(c0) >= img_w) begin
         c1 = '0;
         r1 = HW'(r0) + HW'(1);
      end else begin
         c1 = c0;
         r1 = HW'(r0);
      end
      r2     = (r1 >= img_h) ? '0 : RW'(r1);
      emit   = (WW'(c1) + WW'(1) >= WW'(kern_n)) && (HW'(r2) + HW'(1) >= HW'(kern_n));
      last   = (HW'(r2) + HW'(1) == img_h) && (WW'(c1) + WW'(1) == img_w);
      col_nx = WW'(c1) + WW'(1);
      row_nx = HW'(r2) + HW'(1);
      if (col_nx >= img_w) begin
         col_in = '0;
         row_in = (row_nx >= img_h) ? '0 : RW'(row_nx);
      end else begin
         col_in = CW'(col_nx);
         row_in = r2;
      end
   end

   assign rd_col = c1;

   // position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (en && in_valid) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag.valid <= 1'b0;
      end else if (en) begin
         s1_tag.valid <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tag.emit <= emit;
         s1_tag.last <= last;
         s1_tag.row  <= POS_W'(r2) - POS_W'(half);
         s1_tag.col  <= POS_W'(c1) - POS_W'(half);
         s1_pix      <= in_pix;
         s1_col      <= c1;
      end
   end

endmodule

FILE: hw/rtl/hpbf_line.sv
`timescale 1ns / 1ps
// Line memory: one word per column holding the previous rows, read-modify-write
// with same-column forwarding, plus grouped column sums (stage 1 -> 2).
// Depends on hpbf_pkg.
module hpbf_line
   import hpbf_pkg::*;
#(
   parameter int MAX_KERNEL = 15,
   parameter int MAX_WIDTH  = 2048,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int LW = (MAX_KERNEL - 1) * PIX_W,
   localparam int NG = (MAX_KERNEL - 1 + GRP - 1) / GRP,
   localparam int GW = PIX_W + 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [CW-1:0]    rd_col,
   input  tag_type          s1_tag,
   input  logic [PIX_W-1:0] s1_pix,
   input  logic [CW-1:0]    s1_col,
   input  logic [KN_W-1:0]  kern_n,
   output tag_type          s2_tag,
   output logic [PIX_W-1:0] s2_pix,
   output logic [PIX_W-1:0] s2_center,
   output logic [GW-1:0]    s2_grp [NG]
);

   logic [LW-1:0]    line_mem [MAX_WIDTH];
   logic [LW-1:0]    rd_ff;
   logic [LW-1:0]    wr_data;
   logic             wr_en;
   logic [KN_W-1:0]  cidx;
   logic [PIX_W-1:0] center;
   logic [GW-1:0]    grp [NG];

   // newest row goes into the low byte, oldest drops off the top
   assign wr_en   = en && s1_tag.valid;
   assign wr_data = {rd_ff[LW-PIX_W-1:0], s1_pix};

   // line memory, write-first toward the read port on a same-column hit
   always_ff @(posedge clock) begin
      if (en) begin
         if (wr_en && (s1_col == rd_col)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= line_mem[rd_col];
         end
         if (wr_en) begin
            line_mem[s1_col] <= wr_data;
         end
      end
   end

   // center row pixel and grouped column sum over the n-1 older rows
   always_comb begin
      cidx   = (kern_n >> 1) - KN_W'(1);
      center = '0;
      for (int k = 0; k < MAX_KERNEL - 1; k++) begin
         if (cidx == KN_W'(k)) begin
            center = rd_ff[k*PIX_W +: PIX_W];
         end
      end
      for (int g = 0; g < NG; g++) begin
         grp[g] = '0;
         for (int j = 0; j < GRP; j++) begin
            if ((g * GRP + j < MAX_KERNEL - 1) && (g * GRP + j + 1 < int'(kern_n))) begin
               grp[g] = grp[g] + GW'(rd_ff[(g*GRP+j)*PIX_W +: PIX_W]);
            end
         end
      end
   end

   // stage 2 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag.valid <= 1'b0;
      end else if (en) begin
         s2_tag.valid <= s1_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_tag.emit <= s1_tag.emit;
         s2_tag.last <= s1_tag.last;
         s2_tag.row  <= s1_tag.row;
         s2_tag.col  <= s1_tag.col;
         s2_pix      <= s1_pix;
         s2_center   <= center;
         s2_grp      <= grp;
      end
   end

`ifndef ASSERT_OFF
   // back-to-back hit on one column must see the word just written
   a_forward : assert property (@(posedge clock) disable iff (reset)
      (en && wr_en && (s1_col == rd_col)) |=> (rd_ff[PIX_W-1:0] == $past(s1_pix)))
      else $error("line memory forwarding missed a same-column write");
`endif

endmodule

FILE: hw/rtl/hpbf_win.sv
`timescale 1ns / 1ps
// Window column shift registers, window sum, N*N scaling, clamp and result
// register (stages 2 -> 4 and the output word). Depends on hpbf_pkg.
module hpbf_win
   import hpbf_pkg::*;
#(
   parameter int MAX_KERNEL = 15,
   localparam int NG  = (MAX_KERNEL - 1 + GRP - 1) / GRP,
   localparam int GW  = PIX_W + 2,
   localparam int CSW = $clog2(MAX_KERNEL * 255 + 1),
   localparam int NW  = $clog2(MAX_KERNEL * MAX_KERNEL + 1),
   localparam int PW  = NW + PIX_W,
   localparam int NWG = (MAX_KERNEL + GRP - 1) / GRP,
   localparam int WGW = CSW + 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [KN_W-1:0]  kern_n,
   input  tag_type          s2_tag,
   input  logic [PIX_W-1:0] s2_pix,
   input  logic [PIX_W-1:0] s2_center,
   input  logic [GW-1:0]    s2_grp [NG],
   output logic             rsp_valid,
   output logic [PIX_W-1:0] rsp_value,
   output tag_type          rsp_tag
);

   logic [CSW-1:0]   wc_ff [MAX_KERNEL];
   logic [PIX_W-1:0] cp_ff [MAX_KERNEL];
   logic [CSW-1:0]   colsum;
   logic [NW-1:0]    nn_ff;
   logic [KN_W-1:0]  half;
   logic [PIX_W-1:0] cpsel;
   logic [WGW-1:0]   wgrp [NWG];
   logic [WGW-1:0]   wgrp_ff [NWG];
   logic [PW-1:0]    prod_ff;
   logic [PW-1:0]    winsum, diff;
   logic [PIX_W-1:0] value;
   tag_type          s3_tag, s4_tag;
   logic             rsp_valid_ff;

   // full column sum of the new column
   always_comb begin
      colsum = CSW'(s2_pix);
      for (int g = 0; g < NG; g++) begin
         colsum = colsum + CSW'(s2_grp[g]);
      end
   end

   // window columns and center pixels, newest at index 0
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_KERNEL; k++) begin
            wc_ff[k] <= '0;
            cp_ff[k] <= '0;
         end
      end else if (en && s2_tag.valid) begin
         wc_ff[0] <= colsum;
         cp_ff[0] <= s2_center;
         for (int k = 1; k < MAX_KERNEL; k++) begin
            wc_ff[k] <= wc_ff[k-1];
            cp_ff[k] <= cp_ff[k-1];
         end
      end
   end

   // N*N from the live kernel size
   always_ff @(posedge clock) begin
      nn_ff <= NW'(kern_n) * NW'(kern_n);
   end

   // stage 3: center pick and grouped window sum
   always_comb begin
      half  = kern_n >> 1;
      cpsel = '0;
      for (int k = 0; k < MAX_KERNEL; k++) begin
         if (half == KN_W'(k)) begin
            cpsel = cp_ff[k];
         end
      end
      for (int g = 0; g < NWG; g++) begin
         wgrp[g] = '0;
         for (int j = 0; j < GRP; j++) begin
            if ((g * GRP + j < MAX_KERNEL) && (g * GRP + j < int'(kern_n))) begin
               wgrp[g] = wgrp[g] + WGW'(wc_ff[g*GRP+j]);
            end
         end
      end
   end

   // stage 4: total, subtract and clamp
   always_comb begin
      winsum = '0;
      for (int g = 0; g < NWG; g++) begin
         winsum = winsum + PW'(wgrp_ff[g]);
      end
      diff = prod_ff - winsum;
      if (prod_ff < winsum) begin
         value = '0;
      end else if (diff > PW'(255)) begin
         value = '1;
      end else begin
         value = diff[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_tag.valid <= 1'b0;
         s4_tag.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s3_tag.valid <= s2_tag.valid;
         s4_tag.valid <= s3_tag.valid;
         rsp_valid_ff <= s4_tag.valid && s4_tag.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_tag.emit <= s2_tag.emit;
         s3_tag.last <= s2_tag.last;
         s3_tag.row  <= s2_tag.row;
         s3_tag.col  <= s2_tag.col;
         s4_tag.emit <= s3_tag.emit;
         s4_tag.last <= s3_tag.last;
         s4_tag.row  <= s3_tag.row;
         s4_tag.col  <= s3_tag.col;
         prod_ff     <= PW'(nn_ff) * PW'(cpsel);
         wgrp_ff     <= wgrp;
         rsp_value   <= value;
         rsp_tag     <= s4_tag;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // a result appears only out of an emitting word in the last stage
   a_emit_src : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s4_tag.valid && s4_tag.emit))
      else $error("result word without an emitting source");

   // window state holds while the pipeline is stalled
   a_win_hold : assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(wc_ff[0]) && $stable(cp_ff[0])))
      else $error("window columns moved during a stall");

   // output register mirrors the tag it was loaded with
   a_tag_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_tag.valid && rsp_tag.emit)
      else $error("result word carries a non-emitting tag");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for high_pass_box_filter: streams pixel words,
// predicts each filtered word in-bench and compares against rsp_*.
// Depends on hpbf_pkg and the high_pass_box_filter RTL.
module testbench;
   import hpbf_pkg::*;

   localparam int KMAX       = 15;
   localparam int WMAX       = 2048;
   localparam int HMAX       = 2048;
   localparam int DRAIN      = 12;
   localparam int CYCLE_CAP  = 3000000;
   localparam int RAND_ITEMS = 400;

   // expected filtered word
   typedef struct packed {
      logic             last;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [PIX_W-1:0] value;
   } filt_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;   // [7:0] pixel
   logic                 req_tuser = 1'b0; // [0] start_of_frame
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;        // [7:0] value, [18:8] row, [29:19] col
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_KERNEL_SIZE;
   logic [DIM_W-1:0]     csr_data = '0;

   // predictor state
   logic [7:0]  line_mem [KMAX-1][WMAX];
   int unsigned col_sums_win [KMAX];
   logic [7:0]  center_win [KMAX];
   int unsigned row_pos, col_pos;
   logic [KSZ_W-1:0] kernel_reg;
   logic [DIM_W-1:0] width_reg, height_reg;

   filt_word_type filtered_q [$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          steady = 1'b0;   // no idling on either side when set
   int          hold_off = 0;    // long receiver stall request

   high_pass_box_filter dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic int unsigned eff_kernel();
      int unsigned k;
      k = kernel_reg;
      if (k > KMAX) k = KMAX;
      if (k[0] == 1'b0 && k > 0) k = k - 1;
      if (k < 3) k = 3;
      return k;
   endfunction

   function automatic int unsigned clip_dim(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   function automatic void predict_reset();
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (col_sums_win[i]) begin
         col_sums_win[i] = 0;
         center_win[i] = '0;
      end
      row_pos = 0;
      col_pos = 0;
      kernel_reg = 4'd3;
      width_reg = 12'd512;
      height_reg = 12'd512;
   endfunction

   // advance the filter model by one pixel; queue a word if a window completes
   function automatic void predict_pixel(logic [7:0] pix, logic sof);
      int unsigned n, h, w, ht, r, c, csum, wsum;
      int acc;
      filt_word_type fw;
      n = eff_kernel();
      h = n / 2;
      w = clip_dim(width_reg, WMAX);
      ht = clip_dim(height_reg, HMAX);
      if (sof) begin
         row_pos = 0;
         col_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= ht) row_pos = 0;
      r = row_pos;
      c = col_pos;
      csum = pix;
      for (int k = 0; k + 1 < n; k++) csum += line_mem[k][c];
      for (int k = KMAX - 1; k > 0; k--) begin
         col_sums_win[k] = col_sums_win[k-1];
         center_win[k] = center_win[k-1];
      end
      col_sums_win[0] = csum;
      center_win[0] = line_mem[h-1][c];
      for (int k = KMAX - 2; k > 0; k--) line_mem[k][c] = line_mem[k-1][c];
      line_mem[0][c] = pix;
      if (r + 1 >= n && c + 1 >= n) begin
         wsum = 0;
         for (int k = 0; k < n; k++) wsum += col_sums_win[k];
         acc = int'(n * n * center_win[h]) - int'(wsum);
         if (acc < 0) acc = 0;
         if (acc > 255) acc = 255;
         fw.value = acc[7:0];
         fw.row = POS_W'(r - h);
         fw.col = POS_W'(c - h);
         fw.last = (r + 1 == ht && c + 1 == w);
         filtered_q.push_back(fw);
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= ht) row_pos = 0;
      end
   endfunction

   function automatic int gap_len();
      if ($urandom_range(19) == 0) return $urandom_range(60, 20);
      return $urandom_range(3, 1);
   endfunction

   // receiver: random stalls plus a long hold-off on request
   initial begin
      int gap;
      gap = 0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_tready = 1'b0;
            hold_off--;
         end else if (gap > 0) begin
            rsp_tready = 1'b0;
            gap--;
         end else if (!steady && $urandom_range(3) == 0) begin
            rsp_tready = 1'b0;
            gap = gap_len() - 1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      filt_word_type want;
      logic [31:0] want_data;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (filtered_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: data=%h last=%b", rsp_tdata, rsp_tlast);
         end else begin
            want = filtered_q.pop_front();
            want_data = {2'b00, want.col, want.row, want.value};
            if (rsp_tdata !== want_data || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want %0d/%0d/%0d/%b, got %0d/%0d/%0d/%b",
                           want.value, want.row, want.col, want.last,
                           rsp_tdata[7:0], rsp_tdata[18:8], rsp_tdata[29:19],
                           rsp_tlast);
            end
         end
      end
   end

   task automatic send_pixel(logic [7:0] pix, logic sof);
      int gap;
      if (!steady && $urandom_range(4) == 0) begin
         gap = gap_len();
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = pix;
      req_tuser = sof;
      do @(posedge clock); while (!req_tready);
      predict_pixel(pix, sof);
      @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [DIM_W-1:0] value);
      req_tvalid = 1'b0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KERNEL_SIZE:  kernel_reg = value[KSZ_W-1:0];
         CSR_IMAGE_WIDTH:  width_reg = value;
         CSR_IMAGE_HEIGHT: height_reg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // let the pipeline empty before touching registers
   task automatic drain();
      req_tvalid = 1'b0;
      while (filtered_q.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic setup(logic [DIM_W-1:0] ks, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      drain();
      write_reg(CSR_KERNEL_SIZE, ks);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
   endtask

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   // count pixels of a frame, sof on the first
   task automatic send_frame(int count);
      for (int i = 0; i < count; i++) send_pixel(rand_pixel(), i == 0);
   endtask

   // reset register values: 3x3 kernel over 512-wide rows, into the third row
   task automatic test_reset_values();
      send_frame(2 * 512 + 8);
   endtask

   // clamp extremes on a 3x3 frame
   task automatic test_clamp_extremes();
      setup(12'd3, 12'd3, 12'd3);
      for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 8'd255 : 8'd0, i == 0);
      for (int i = 0; i < 9; i++) send_pixel(8'd255, i == 0);
      for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 8'd0 : 8'd255, i == 0);
   endtask

   // even, zero and maximum kernel codes
   task automatic test_kernel_codes();
      logic [DIM_W-1:0] codes [5] = '{12'd0, 12'd2, 12'd4, 12'd14, 12'd15};
      int n;
      foreach (codes[i]) begin
         n = (codes[i] < 3) ? 3 : (codes[i][0] ? codes[i] : codes[i] - 1);
         setup(codes[i], DIM_W'(n + 1), DIM_W'(n + 1));
         send_frame((n + 1) * (n + 1));
      end
   endtask

   // zero and oversize dimensions, kernel wider than frame, wrap without sof
   task automatic test_size_limits();
      setup(12'd3, 12'd0, 12'd0);
      send_frame(4);
      setup(12'd3, 12'd3, 12'd4095);
      send_frame(12);
      setup(12'd15, 12'd5, 12'd5);
      send_frame(30);
      setup(12'd3, 12'd4, 12'd4);
      send_frame(40);
   endtask

   // random configurations and frames, with some sof noise
   task automatic test_random_frames();
      int total, w, h, n, cnt;
      total = 0;
      while (total < RAND_ITEMS) begin
         steady = ($urandom_range(4) == 0);
         n = $urandom_range(15);
         w = ($urandom_range(9) == 0) ? $urandom_range(200, 41) : $urandom_range(40, 1);
         h = $urandom_range(30, 1);
         setup(DIM_W'(n), DIM_W'(w), DIM_W'(h));
         for (int f = 0; f < 3 && total < RAND_ITEMS; f++) begin
            cnt = w * h;
            if ($urandom_range(5) == 0) cnt = $urandom_range(cnt, 1);
            if ($urandom_range(5) == 0) cnt = cnt + $urandom_range(w, 1);
            for (int i = 0; i < cnt && total < RAND_ITEMS; i++) begin
               send_pixel(rand_pixel(), i == 0 || $urandom_range(299) == 0);
               total++;
            end
         end
      end
      steady = 1'b0;
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      setup(12'd5, 12'd10, 12'd10);
      hold_off = 300;
      send_frame(100);
      send_frame(100);
   endtask

   initial begin
      predict_reset();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_values();
      test_clamp_extremes();
      test_kernel_codes();
      test_size_limits();
      test_random_frames();
      test_backpressure();
      drain();
      repeat (DRAIN) @(negedge clock);
      if (mismatches == 0 && filtered_q.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
